// ===== rtl/core/alarm_loop_zone_classifier_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ALARM_LOOP_ZONE_CLASSIFIER_MACROS_SVH
`define ALARM_LOOP_ZONE_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
`define ALZC_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("alzc assertion failed");
`define ALZC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alzc assertion failed");
`else
`define ALZC_ASSERT(lbl, expr)
`define ALZC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/alzc_pkg.sv =====
package alzc_pkg;

  localparam int CHAN_W     = 4;
  localparam int MASK_BITS  = 15;
  localparam int RATIO_W    = 16;
  localparam int CNT_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_RATIO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_RATIO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAMPER_RATIO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT = 3'd4;

  localparam logic [MASK_BITS-1:0] RST_ENABLE_MASK  = 15'd0;
  localparam logic [RATIO_W-1:0]   RST_SHORT_RATIO  = 16'd54395;
  localparam logic [RATIO_W-1:0]   RST_NORMAL_RATIO = 16'd33915;
  localparam logic [RATIO_W-1:0]   RST_TAMPER_RATIO = 16'd12288;
  localparam logic [CNT_W-1:0]     RST_REPEAT_COUNT = 8'd240;

  typedef enum logic [2:0] {
    ST_NORMAL    = 3'd0,
    ST_SHORTED   = 3'd1,
    ST_TRIGGERED = 3'd2,
    ST_TAMPER    = 3'd3,
    ST_ERROR     = 3'd4
  } loop_state_t;

  typedef struct packed {
    logic [RATIO_W-1:0] short_ratio;
    logic [RATIO_W-1:0] normal_ratio;
    logic [RATIO_W-1:0] tamper_ratio;
  } ratios_t;

  typedef struct packed {
    logic             prev_abnormal;
    loop_state_t      reported_state;
    logic [CNT_W-1:0] repeat_counter;
  } ent_t;

  typedef struct packed {
    logic        emit;
    logic        periodic;
    loop_state_t shown;
  } upd_t;

endpackage

// ===== rtl/core/alzc_if.sv =====
interface alzc_in_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                          valid;
  logic                          ready;
  logic [alzc_pkg::CHAN_W-1:0]   channel;
  logic [SAMPLE_BITS-1:0]        sample_value;
  logic [SAMPLE_BITS-1:0]        reference_value;

  modport source (output valid, channel, sample_value, reference_value, input ready);
  modport sink   (input valid, channel, sample_value, reference_value, output ready);
endinterface

interface alzc_out_if;
  logic                        valid;
  logic                        ready;
  logic [alzc_pkg::CHAN_W-1:0] report_channel;
  logic [2:0]                  loop_state;
  logic                        not_normal;
  logic                        periodic;

  modport source (output valid, report_channel, loop_state, not_normal, periodic,
                  input ready);
  modport sink   (input valid, report_channel, loop_state, not_normal, periodic,
                  output ready);
endinterface

interface alzc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [alzc_pkg::CFG_IDX_W-1:0]  index;
  logic [alzc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/alzc_ram.sv =====
module alzc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 15
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/alzc_zone.sv =====
module alzc_zone #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                  clk,
  input  logic                  load,
  input  logic [SAMPLE_BITS-1:0] smp,
  input  logic [SAMPLE_BITS-1:0] refv,
  input  alzc_pkg::ratios_t     ratios,
  output alzc_pkg::loop_state_t zone
);

  localparam int PW = alzc_pkg::RATIO_W + SAMPLE_BITS;

  logic [PW-1:0] scaled_r, t_short_r, t_norm_r, t_tamp_r;
  logic          le_r;

  always_ff @(posedge clk) begin
    if (load) begin
      scaled_r  <= {smp, {alzc_pkg::RATIO_W{1'b0}}};
      t_short_r <= PW'(ratios.short_ratio) * PW'(refv);
      t_norm_r  <= PW'(ratios.normal_ratio) * PW'(refv);
      t_tamp_r  <= PW'(ratios.tamper_ratio) * PW'(refv);
      le_r      <= (smp <= refv);
    end
  end

  always_comb begin
    if (le_r && scaled_r > t_short_r) begin
      zone = alzc_pkg::ST_SHORTED;
    end else if (scaled_r <= t_short_r && scaled_r > t_norm_r) begin
      zone = alzc_pkg::ST_NORMAL;
    end else if (scaled_r <= t_norm_r && scaled_r > t_tamp_r) begin
      zone = alzc_pkg::ST_TRIGGERED;
    end else if (scaled_r <= t_tamp_r) begin
      zone = alzc_pkg::ST_TAMPER;
    end else begin
      zone = alzc_pkg::ST_ERROR;
    end
  end

endmodule

// ===== rtl/core/alzc_update.sv =====
module alzc_update (
  input  alzc_pkg::ent_t              old_ent,
  input  alzc_pkg::loop_state_t       zone,
  input  logic [alzc_pkg::CNT_W-1:0]  repeat_count,
  output alzc_pkg::ent_t              new_ent,
  output alzc_pkg::upd_t              upd
);

  logic [alzc_pkg::CNT_W-1:0] cnt_inc;
  alzc_pkg::loop_state_t      shown;

  always_comb begin
    cnt_inc = old_ent.repeat_counter + 1'b1;
    shown   = alzc_pkg::ST_NORMAL;
    if (zone != alzc_pkg::ST_NORMAL && old_ent.prev_abnormal) begin
      shown = zone;
    end
    new_ent.prev_abnormal  = (zone != alzc_pkg::ST_NORMAL);
    new_ent.reported_state = shown;
    upd.shown              = shown;
    if (old_ent.reported_state != shown) begin
      new_ent.repeat_counter = '0;
      upd.emit               = 1'b1;
      upd.periodic           = 1'b0;
    end else if (cnt_inc < repeat_count) begin
      new_ent.repeat_counter = cnt_inc;
      upd.emit               = 1'b0;
      upd.periodic           = 1'b0;
    end else begin
      new_ent.repeat_counter = '0;
      upd.emit               = 1'b1;
      upd.periodic           = 1'b1;
    end
  end

endmodule

// ===== rtl/core/alarm_loop_zone_classifier.sv =====
// Channel  Dir  Fields
// in_if    in   channel, sample_value, reference_value
// out_if   out  report_channel, loop_state, not_normal, periodic
// cfg_if   in   index, data (always ready)
//
// One item per cycle sustained while out_if does not stall; out_if.valid is set when the
// read-modify-write stage emits a report. The per-channel state RAM is read at accept and
// written back as that stage fires; a one-entry bypass covers an item that follows its own
// channel directly. Synchronous active-low reset clears the per-channel valid bits, so all
// state reads as reset at once. A stalled out_if holds the update stage and in_if.ready.
`include "alarm_loop_zone_classifier_macros.svh"

module alarm_loop_zone_classifier #(
  parameter int NUM_CHANNELS = 15,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  alzc_in_if.sink     in_if,
  alzc_out_if.source  out_if,
  alzc_cfg_if.sink    cfg_if
);

  localparam int AW = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1;
  localparam int EW = $bits(alzc_pkg::ent_t);

  logic [alzc_pkg::MASK_BITS-1:0] mask_r;
  alzc_pkg::ratios_t              ratios_r;
  logic [alzc_pkg::CNT_W-1:0]     repeat_count_r;

  logic                        in_acc, s1_adv, s1_fire, wr_en, in_en;
  logic [4:0]                  in_ch_ext;
  logic [AW-1:0]               in_addr;
  logic [alzc_pkg::MASK_BITS:0] mask_ext;

  logic                        s1_valid_r, s1_en_r, rd_vld_r;
  logic [alzc_pkg::CHAN_W-1:0] s1_ch_r;
  logic [AW-1:0]               s1_addr_r;

  logic                        lw_valid_r;
  logic [AW-1:0]               lw_addr_r;
  alzc_pkg::ent_t              lw_data_r;
  logic [(1 << AW)-1:0]        vld_r;

  logic [EW-1:0]               rdata;
  logic                        fwd_hit;
  alzc_pkg::ent_t              old_ent, new_ent;
  alzc_pkg::upd_t              upd;
  alzc_pkg::loop_state_t       zone;

  logic                        out_valid_r;
  logic [alzc_pkg::CHAN_W-1:0] out_ch_r;
  alzc_pkg::loop_state_t       out_state_r;
  logic                        out_periodic_r;

  // configuration
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r                <= alzc_pkg::RST_ENABLE_MASK;
      ratios_r.short_ratio  <= alzc_pkg::RST_SHORT_RATIO;
      ratios_r.normal_ratio <= alzc_pkg::RST_NORMAL_RATIO;
      ratios_r.tamper_ratio <= alzc_pkg::RST_TAMPER_RATIO;
      repeat_count_r        <= alzc_pkg::RST_REPEAT_COUNT;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        alzc_pkg::CFG_ENABLE_MASK:  mask_r <= cfg_if.data[alzc_pkg::MASK_BITS-1:0];
        alzc_pkg::CFG_SHORT_RATIO:  ratios_r.short_ratio <= cfg_if.data;
        alzc_pkg::CFG_NORMAL_RATIO: ratios_r.normal_ratio <= cfg_if.data;
        alzc_pkg::CFG_TAMPER_RATIO: ratios_r.tamper_ratio <= cfg_if.data;
        alzc_pkg::CFG_REPEAT_COUNT: repeat_count_r <= cfg_if.data[alzc_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // accept stage
  assign s1_adv      = !out_valid_r || out_if.ready;
  assign in_if.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_if.valid && in_if.ready;
  assign in_ch_ext   = {1'b0, in_if.channel};
  assign in_addr     = in_ch_ext[AW-1:0];
  assign mask_ext    = {1'b0, mask_r};
  assign in_en       = ({1'b0, in_ch_ext} < 6'(NUM_CHANNELS)) &&
                       (in_if.channel < 4'(alzc_pkg::MASK_BITS)) &&
                       mask_ext[in_if.channel];

  alzc_zone #(.SAMPLE_BITS(SAMPLE_BITS)) u_zone (
    .clk    (clk),
    .load   (in_acc),
    .smp    (in_if.sample_value),
    .refv   (in_if.reference_value),
    .ratios (ratios_r),
    .zone   (zone)
  );

  alzc_ram #(.WIDTH(EW), .DEPTH(NUM_CHANNELS)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr_r),
    .wdata (new_ent),
    .re    (in_acc),
    .raddr (in_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_en_r   <= in_en;
      s1_ch_r   <= in_if.channel;
      s1_addr_r <= in_addr;
      rd_vld_r  <= in_en && vld_r[in_addr];
    end
  end

  // read-modify-write stage
  assign s1_fire = s1_valid_r && s1_adv;
  assign wr_en   = s1_fire && s1_en_r;
  assign fwd_hit = lw_valid_r && (lw_addr_r == s1_addr_r);

  always_comb begin
    if (fwd_hit) begin
      old_ent = lw_data_r;
    end else if (rd_vld_r) begin
      old_ent = alzc_pkg::ent_t'(rdata);
    end else begin
      old_ent = '0;
    end
  end

  alzc_update u_update (
    .old_ent      (old_ent),
    .zone         (zone),
    .repeat_count (repeat_count_r),
    .new_ent      (new_ent),
    .upd          (upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r <= 1'b0;
      vld_r      <= '0;
    end else if (wr_en) begin
      lw_valid_r        <= 1'b1;
      vld_r[s1_addr_r]  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lw_addr_r <= s1_addr_r;
      lw_data_r <= new_ent;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wr_en && upd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && upd.emit) begin
      out_ch_r       <= s1_ch_r;
      out_state_r    <= upd.shown;
      out_periodic_r <= upd.periodic;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.report_channel = out_ch_r;
  assign out_if.loop_state     = out_state_r;
  assign out_if.not_normal     = (out_state_r != alzc_pkg::ST_NORMAL);
  assign out_if.periodic       = out_periodic_r;

  `ALZC_ASSERT(a_wr_in_range, !wr_en || ({2'b0, s1_ch_r} < 6'(NUM_CHANNELS)))
  `ALZC_ASSERT_NEXT(a_emit_shows, wr_en && upd.emit, out_valid_r)
  `ALZC_ASSERT_NEXT(a_bypass, wr_en && in_acc && in_en && (in_addr == s1_addr_r), fwd_hit)
  `ALZC_ASSERT(a_stall_holds, !(out_valid_r && !out_if.ready && s1_valid_r) || !in_if.ready)

endmodule

// ===== verif/tb.sv =====
module tb;
  import alzc_pkg::*;

  localparam int NUM_CH = 15;
  localparam int SMP_W = 12;
  localparam int SMP_MAX = (1 << SMP_W) - 1;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int IDLE_LIMIT = 50000;
  localparam int DRAIN_CYCLES = 6;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [SMP_W-1:0]  sample_value;
    logic [SMP_W-1:0]  reference_value;
  } sample_t;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    loop_state_t       state;
    logic              not_normal;
    logic              periodic;
  } report_t;

  logic clk = 1'b0;
  logic rst_n;

  alzc_in_if #(.SAMPLE_BITS(SMP_W)) in_if ();
  alzc_out_if out_if ();
  alzc_cfg_if cfg_if ();

  alarm_loop_zone_classifier #(
    .NUM_CHANNELS(NUM_CH),
    .SAMPLE_BITS(SMP_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [MASK_BITS-1:0] enable_mask = RST_ENABLE_MASK;
  logic [RATIO_W-1:0]   short_ratio_q = RST_SHORT_RATIO;
  logic [RATIO_W-1:0]   normal_ratio_q = RST_NORMAL_RATIO;
  logic [RATIO_W-1:0]   tamper_ratio_q = RST_TAMPER_RATIO;
  logic [CNT_W-1:0]     repeat_count_q = RST_REPEAT_COUNT;

  logic        prev_abnormal [NUM_CH];
  loop_state_t shown_state [NUM_CH];
  logic [CNT_W-1:0] same_count [NUM_CH];

  sample_t sample_queue [$];
  report_t pending_reports [$];
  sample_t next_sample;
  report_t want_report;
  report_t new_report;

  int pushed = 0;
  int accepted = 0;
  int reports_seen = 0;
  int repeat_reports = 0;
  int errors = 0;
  int reg_writes = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit in_rush = 1'b0;
  bit out_rush = 1'b0;
  bit in_fire = 1'b0;

  function automatic loop_state_t zone_of_sample(logic [SMP_W-1:0] s, logic [SMP_W-1:0] r);
    logic [31:0] scaled, t_short, t_normal, t_tamper;
    scaled = 32'(s) << 16;
    t_short = 32'(short_ratio_q) * 32'(r);
    t_normal = 32'(normal_ratio_q) * 32'(r);
    t_tamper = 32'(tamper_ratio_q) * 32'(r);
    if (s <= r && scaled > t_short) return ST_SHORTED;
    if (scaled <= t_short && scaled > t_normal) return ST_NORMAL;
    if (scaled <= t_normal && scaled > t_tamper) return ST_TRIGGERED;
    if (scaled <= t_tamper) return ST_TAMPER;
    return ST_ERROR;
  endfunction

  function automatic bit advance_channel(input sample_t smp, output report_t rep);
    loop_state_t zone;
    loop_state_t shown;
    int ch;
    ch = smp.channel;
    rep = '0;
    if (ch >= NUM_CH || ch >= MASK_BITS) return 1'b0;
    if (!enable_mask[ch]) return 1'b0;
    zone = zone_of_sample(smp.sample_value, smp.reference_value);
    shown = ST_NORMAL;
    if (zone != ST_NORMAL) begin
      if (prev_abnormal[ch]) shown = zone;
      prev_abnormal[ch] = 1'b1;
    end else begin
      prev_abnormal[ch] = 1'b0;
    end
    if (shown_state[ch] != shown) begin
      same_count[ch] = '0;
      shown_state[ch] = shown;
      rep.periodic = 1'b0;
    end else begin
      same_count[ch] = same_count[ch] + 1'b1;
      if (same_count[ch] < repeat_count_q) return 1'b0;
      same_count[ch] = '0;
      rep.periodic = 1'b1;
    end
    rep.channel = smp.channel;
    rep.state = shown;
    rep.not_normal = (shown != ST_NORMAL);
    return 1'b1;
  endfunction

  function automatic int pick_gap(bit rush);
    int roll;
    if (rush) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_sample(int ch, int s, int r);
    sample_t item;
    item.channel = CHAN_W'(ch);
    item.sample_value = SMP_W'(s);
    item.reference_value = SMP_W'(r);
    sample_queue.push_back(item);
    pushed++;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_ENABLE_MASK:  enable_mask = value[MASK_BITS-1:0];
      CFG_SHORT_RATIO:  short_ratio_q = value[RATIO_W-1:0];
      CFG_NORMAL_RATIO: normal_ratio_q = value[RATIO_W-1:0];
      CFG_TAMPER_RATIO: tamper_ratio_q = value[RATIO_W-1:0];
      CFG_REPEAT_COUNT: repeat_count_q = value[CNT_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    int n;
    n = 0;
    while ((accepted != pushed || pending_reports.size() != 0) && n < IDLE_LIMIT) begin
      @(negedge clk);
      n++;
    end
    if (pending_reports.size() != 0) begin
      $display("%0t: %0d expected reports never arrived, oldest ch=%0d state=%0d",
               $time, pending_reports.size(), pending_reports[0].channel,
               pending_reports[0].state);
      errors++;
      pending_reports.delete();
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_if.valid || in_fire) begin
        if (in_gap > 0) begin
          in_if.valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (sample_queue.size() > 0) begin
          next_sample = sample_queue.pop_front();
          in_if.valid <= 1'b1;
          in_if.channel <= next_sample.channel;
          in_if.sample_value <= next_sample.sample_value;
          in_if.reference_value <= next_sample.reference_value;
          in_gap <= pick_gap(in_rush);
          if ($urandom_range(0, 49) == 0) in_rush <= !in_rush;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_gap > 0) begin
        out_if.ready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        out_if.ready <= 1'b1;
        out_gap <= pick_gap(out_rush);
        if ($urandom_range(0, 63) == 0) out_rush <= !out_rush;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_if.valid && in_if.ready;
      if (out_if.valid && out_if.ready) begin
        reports_seen++;
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected report: expected none, got ch=%0d state=%0d nn=%0b per=%0b",
                   $time, out_if.report_channel, out_if.loop_state, out_if.not_normal,
                   out_if.periodic);
          errors++;
        end else begin
          want_report = pending_reports.pop_front();
          if (want_report.periodic) repeat_reports++;
          if (out_if.report_channel !== want_report.channel ||
              out_if.loop_state !== want_report.state ||
              out_if.not_normal !== want_report.not_normal ||
              out_if.periodic !== want_report.periodic) begin
            $display("%0t: report mismatch: expected ch=%0d state=%0d nn=%0b per=%0b, got ch=%0d state=%0d nn=%0b per=%0b",
                     $time, want_report.channel, want_report.state, want_report.not_normal,
                     want_report.periodic, out_if.report_channel, out_if.loop_state,
                     out_if.not_normal, out_if.periodic);
            errors++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        accepted++;
        next_sample.channel = in_if.channel;
        next_sample.sample_value = in_if.sample_value;
        next_sample.reference_value = in_if.reference_value;
        if (advance_channel(next_sample, new_report)) pending_reports.push_back(new_report);
      end
    end
  end

  initial begin
    #3200000;
    $display("%0t: run timed out with %0d reports pending", $time, pending_reports.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int phase, run, k, ch, s, r, base, a, b, c, t;
    logic [CFG_DATA_W-1:0] mask_word;
    int rep_cnt;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.channel = '0;
    in_if.sample_value = '0;
    in_if.reference_value = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      prev_abnormal[i] = 1'b0;
      shown_state[i] = ST_NORMAL;
      same_count[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // all channels disabled out of reset
    push_sample(0, 3500, 4000);
    push_sample(3, 100, 4000);
    push_sample(0, 3500, 4000);
    wait_idle();

    write_reg(CFG_ENABLE_MASK, 16'hFFFF);
    write_reg(CFG_SHORT_RATIO, RST_SHORT_RATIO);
    write_reg(CFG_NORMAL_RATIO, RST_NORMAL_RATIO);
    write_reg(CFG_TAMPER_RATIO, RST_TAMPER_RATIO);
    write_reg(CFG_REPEAT_COUNT, {8'hA5, 8'd3});
    push_sample(0, 3500, 4000);
    push_sample(0, 3500, 4000);
    push_sample(0, 500, 4000);
    push_sample(0, 1500, 4000);
    push_sample(0, SMP_MAX, 4000);
    push_sample(0, 2500, 4000);
    push_sample(0, 2500, 4000);
    push_sample(0, 2500, 4000);
    push_sample(0, 2500, 4000);
    push_sample(14, 750, 4000);
    push_sample(14, 750, 4000);
    push_sample(14, 751, 4000);
    push_sample(15, 3500, 4000);
    push_sample(7, 0, 0);
    push_sample(7, 0, 0);
    push_sample(13, SMP_MAX, SMP_MAX);
    push_sample(13, SMP_MAX, SMP_MAX);
    push_sample(12, SMP_MAX, 0);
    push_sample(12, SMP_MAX, 0);
    wait_idle();

    // repeat count of zero: every unchanged sample reports
    write_reg(CFG_REPEAT_COUNT, 16'h0100);
    write_reg(CFG_ENABLE_MASK, 16'h0003);
    push_sample(1, 2500, 4000);
    push_sample(1, 2500, 4000);
    push_sample(1, 2500, 4000);
    push_sample(2, 500, 4000);
    push_sample(0, 500, 4000);
    push_sample(0, 500, 4000);
    wait_idle();
    for (int i = CFG_REPEAT_COUNT + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      a = $urandom_range(0, 65535);
      b = $urandom_range(0, 65535);
      c = $urandom_range(0, 65535);
      case (phase)
        0: begin
          mask_word = 16'hFFFF;
          a = RST_SHORT_RATIO;
          b = RST_NORMAL_RATIO;
          c = RST_TAMPER_RATIO;
          rep_cnt = 1;
        end
        1: begin
          mask_word = CFG_DATA_W'($urandom) | 16'h0001;
          rep_cnt = $urandom_range(2, 5);
        end
        2: begin
          mask_word = 16'h7FFF ^ (16'h0001 << $urandom_range(0, MASK_BITS - 1));
          rep_cnt = 255;
        end
        3: begin
          mask_word = CFG_DATA_W'($urandom | $urandom) | 16'h0001;
          a = 65535;
          b = 65535;
          c = 0;
          rep_cnt = 3;
        end
        4: begin
          mask_word = 16'hFFFF;
          a = 0;
          b = 0;
          c = 0;
          rep_cnt = 4;
        end
        default: begin
          mask_word = CFG_DATA_W'($urandom | $urandom) | 16'h0001;
          rep_cnt = $urandom_range(1, 8);
        end
      endcase
      if (phase == 1 || phase >= 5) begin
        if (a < b) begin t = a; a = b; b = t; end
        if (b < c) begin t = b; b = c; c = t; end
        if (a < b) begin t = a; a = b; b = t; end
      end
      write_reg(CFG_ENABLE_MASK, mask_word);
      write_reg(CFG_SHORT_RATIO, CFG_DATA_W'(a));
      write_reg(CFG_NORMAL_RATIO, CFG_DATA_W'(b));
      write_reg(CFG_TAMPER_RATIO, CFG_DATA_W'(c));
      write_reg(CFG_REPEAT_COUNT, {8'($urandom), 8'(rep_cnt)});

      k = 0;
      while (k < ITEMS_PER_PHASE) begin
        ch = $urandom_range(0, 15);
        case ($urandom_range(0, 9))
          0: r = SMP_MAX;
          1: r = $urandom_range(0, 15);
          default: r = $urandom_range(0, SMP_MAX);
        endcase
        case ($urandom_range(0, 9))
          0: base = $urandom_range(0, SMP_MAX);
          1: base = (r < SMP_MAX) ? r + 1 + int'($urandom_range(0, SMP_MAX - 1 - r)) : SMP_MAX;
          default: base = (r * int'($urandom_range(0, 65535))) >>> 16;
        endcase
        run = $urandom_range(1, 6);
        repeat (run) begin
          s = base + int'($urandom_range(0, 2)) - 1;
          if (s < 0) s = 0;
          if (s > SMP_MAX) s = SMP_MAX;
          push_sample(ch, s, r);
          k++;
        end
      end
      wait_idle();
    end

    $display("Covered %0d samples under %0d register writes; %0d reports checked",
             accepted, reg_writes, reports_seen);
    $display("Of those reports %0d were repeats and %0d were state changes",
             repeat_reports, reports_seen - repeat_reports);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
